// ===== design/spmd_pkg.sv =====
// shared constants, field layout and control types for the shortest path unit
`default_nettype none

package spmd_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_BITS    = 20;

  localparam int VIDX_BITS = $clog2(MAX_VERTICES);
  localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);
  localparam int CELL_BITS = 2 * VIDX_BITS;
  localparam int CELLS     = 1 << CELL_BITS;
  localparam int SUM_BITS  = ((WEIGHT_BITS > DIST_BITS) ? WEIGHT_BITS : DIST_BITS) + 1;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  // fixed field widths of the stream items
  localparam int VFIELD_BITS = 4;
  localparam int WFIELD_BITS = 16;
  localparam int CFG_BITS    = 5;

  localparam logic [CFG_BITS-1:0] VCOUNT_RESET = CFG_BITS'(9);

  // slave tdata layout, lowest bit first
  localparam int FROM_LSB    = 0;
  localparam int TO_LSB      = FROM_LSB + VFIELD_BITS;
  localparam int WEIGHT_LSB  = TO_LSB + VFIELD_BITS;
  localparam int PRESENT_LSB = WEIGHT_LSB + WFIELD_BITS;
  localparam int SOURCE_LSB  = PRESENT_LSB + 1;
  localparam int TARGET_LSB  = SOURCE_LSB + VFIELD_BITS;
  localparam int S_TDATA_BITS = ((TARGET_LSB + VFIELD_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS = ((DIST_BITS + 7) / 8) * 8;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic load_edge;
    logic start_query;
    logic scan_en;
    logic pick;
    logic relax_en;
    logic out_load;
  } spmd_cmd_t;

  typedef struct packed {
    logic query_bad;
    logic idx_last;
    logic pick_found;
    logic out_free;
  } spmd_status_t;

endpackage

`default_nettype wire

// ===== design/spmd_ram.sv =====
// generic single-port ram with registered read
`default_nettype none

module spmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== design/spmd_datapath.sv =====
// distance registers, edge store, minimum search and relaxation datapath
`default_nettype none

module spmd_datapath (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [spmd_pkg::CFG_BITS-1:0]          cfg_data,
  input  wire logic [spmd_pkg::S_TDATA_BITS-1:0]      s_tdata,
  input  wire spmd_pkg::spmd_cmd_t                    cmd,
  output spmd_pkg::spmd_status_t                      status,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic [spmd_pkg::M_TDATA_BITS-1:0]           m_tdata,
  output logic [0:0]                                  m_tuser
);

  localparam int MAXV = spmd_pkg::MAX_VERTICES;
  localparam int VB   = spmd_pkg::VIDX_BITS;
  localparam int CB   = spmd_pkg::CNT_BITS;
  localparam int DB   = spmd_pkg::DIST_BITS;
  localparam int WB   = spmd_pkg::WEIGHT_BITS;
  localparam int SB   = spmd_pkg::SUM_BITS;
  localparam int FB   = spmd_pkg::VFIELD_BITS;

  // input fields
  logic [FB-1:0] from_f, to_f, source_f, target_f;
  logic [spmd_pkg::WFIELD_BITS-1:0] weight_f;
  logic present_f;

  assign from_f    = s_tdata[spmd_pkg::FROM_LSB +: FB];
  assign to_f      = s_tdata[spmd_pkg::TO_LSB +: FB];
  assign weight_f  = s_tdata[spmd_pkg::WEIGHT_LSB +: spmd_pkg::WFIELD_BITS];
  assign present_f = s_tdata[spmd_pkg::PRESENT_LSB];
  assign source_f  = s_tdata[spmd_pkg::SOURCE_LSB +: FB];
  assign target_f  = s_tdata[spmd_pkg::TARGET_LSB +: FB];

  logic [spmd_pkg::CFG_BITS-1:0] vcount;
  logic [CB-1:0]      n_eff;

  logic [DB-1:0]      path_len [MAXV];
  logic [MAXV-1:0]    finite;
  logic [MAXV-1:0]    settled;
  logic [spmd_pkg::CELLS-1:0] edge_ok;

  logic [VB-1:0]      idx;
  logic [VB-1:0]      best_idx;
  logic [DB-1:0]      best_dist;
  logic               best_found;
  logic [VB-1:0]      u;
  logic [DB-1:0]      u_dist;
  logic               rx_valid;
  logic [VB-1:0]      rx_idx;
  logic [VB-1:0]      tgt;
  logic               bad;

  logic [DB-1:0]      res_dist;
  logic               res_reach;

  logic                          load_in_range;
  logic [spmd_pkg::CELL_BITS-1:0] load_cell;
  logic [spmd_pkg::CELL_BITS-1:0] ram_addr;
  logic                          ram_we;
  logic [WB-1:0]                 ram_rdata;

  logic          scan_take;
  logic [SB-1:0] sum;
  logic [DB-1:0] cand;
  logic          relax_take;
  logic [VB-1:0] src_idx;

  // out-of-range counts fold onto 1 and the matrix size
  always_comb begin
    if (vcount == '0) begin
      n_eff = CB'(1);
    end else if (int'(vcount) > MAXV) begin
      n_eff = CB'(MAXV);
    end else begin
      n_eff = CB'(vcount);
    end
  end

  assign status.query_bad  = (int'(source_f) >= int'(n_eff)) || (int'(target_f) >= int'(n_eff));
  assign status.idx_last   = (CB'(idx) + CB'(1)) == n_eff;
  assign status.pick_found = best_found;
  assign status.out_free   = !m_tvalid || m_tready;

  assign load_in_range = (int'(from_f) < MAXV) && (int'(to_f) < MAXV);
  assign load_cell     = {VB'(from_f), VB'(to_f)};
  assign ram_we        = cmd.load_edge && load_in_range;
  assign ram_addr      = cmd.load_edge ? load_cell : {u, idx};
  assign src_idx       = VB'(source_f);

  spmd_ram #(
    .WIDTH (WB),
    .DEPTH (spmd_pkg::CELLS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (WB'(weight_f)),
    .rdata (ram_rdata)
  );

  assign scan_take = cmd.scan_en && !settled[idx] && finite[idx]
                     && (!best_found || path_len[idx] < best_dist);

  // path sums saturate at the top of the distance range
  assign sum  = SB'(u_dist) + SB'(ram_rdata);
  assign cand = (sum > SB'(spmd_pkg::DIST_MAX)) ? spmd_pkg::DIST_MAX : sum[DB-1:0];

  assign relax_take = rx_valid && !settled[rx_idx] && edge_ok[{u, rx_idx}]
                      && (!finite[rx_idx] || cand < path_len[rx_idx]);

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount     <= spmd_pkg::VCOUNT_RESET;
      edge_ok    <= '0;
      finite     <= '0;
      settled    <= '0;
      best_found <= 1'b0;
      rx_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount <= cfg_data;
      end
      if (ram_we) begin
        edge_ok[load_cell] <= present_f;
      end
      rx_valid <= cmd.relax_en;
      if (cmd.start_query) begin
        finite     <= status.query_bad ? '0 : (MAXV'(1) << src_idx);
        settled    <= '0;
        best_found <= 1'b0;
      end else begin
        if (relax_take) begin
          finite[rx_idx] <= 1'b1;
        end
        if (scan_take) begin
          best_found <= 1'b1;
        end
        if (cmd.pick) begin
          settled[best_idx] <= 1'b1;
          best_found        <= 1'b0;
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      path_len[src_idx] <= '0;
      idx               <= '0;
      tgt               <= VB'(target_f);
      bad               <= status.query_bad;
    end else begin
      if (relax_take) begin
        path_len[rx_idx] <= cand;
      end
      if (cmd.scan_en || cmd.relax_en) begin
        idx <= status.idx_last ? '0 : idx + VB'(1);
      end
    end
    if (scan_take) begin
      best_idx  <= idx;
      best_dist <= path_len[idx];
    end
    if (cmd.pick) begin
      u      <= best_idx;
      u_dist <= best_dist;
    end
    rx_idx <= idx;
    if (cmd.out_load) begin
      res_dist  <= res_reach ? path_len[tgt] : '0;
    end
  end

  // result flag is formed combinationally and captured with the distance
  logic reach_reg;
  assign res_reach = !bad && finite[tgt];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      reach_reg <= res_reach;
    end
  end

  assign m_tdata = spmd_pkg::M_TDATA_BITS'(res_dist);
  assign m_tuser = reach_reg;

endmodule

`default_nettype wire

// ===== design/spmd_controller.sv =====
// sequencer for edge loads and the scan and relax rounds of a query
`default_nettype none

module spmd_controller (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  input  wire logic                   mode,
  input  wire spmd_pkg::spmd_status_t status,
  output logic                        s_tready,
  output spmd_pkg::spmd_cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_PICK  = 3'd2;
  localparam logic [2:0] ST_RELAX = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (mode == spmd_pkg::MODE_LOAD) begin
            cmd.load_edge = 1'b1;
          end else begin
            cmd.start_query = 1'b1;
            state_next      = status.query_bad ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.idx_last) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (status.pick_found) begin
          cmd.pick   = 1'b1;
          state_next = ST_RELAX;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RELAX: begin
        cmd.relax_en = 1'b1;
        if (status.idx_last) begin
          state_next = ST_DRAIN;
        end
      end
      // last relaxation leaves the pipeline stage here
      ST_DRAIN: begin
        state_next = ST_SCAN;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/shortest_path_matrix_dijkstra_unit.sv =====
// Edge load: no result; the next transaction can be accepted in the following cycle.
// Query: each round scans the distances, picks the nearest unsettled reached vertex and then
// relaxes its matrix row through the weight ram; the result waits for a free output slot, and
// the input is free again once the result is loaded.
// Rejected query (source or target not in use): no search, the result is unreachable with distance 0.
// Reset (rst, synchronous): no edges, vertex_count 9, no output pending; no clearing pass.
`default_nettype none

module shortest_path_matrix_dijkstra_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [spmd_pkg::CFG_BITS-1:0]     cfg_data,   // vertex_count
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // from_vertex, to_vertex, edge_weight, edge_present, source_vertex, target_vertex
  input  wire logic [spmd_pkg::S_TDATA_BITS-1:0] s_tdata,
  input  wire logic [0:0]                        s_tuser,    // mode
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [spmd_pkg::M_TDATA_BITS-1:0]      m_tdata,    // distance
  output logic [0:0]                             m_tuser     // reachable
);

  spmd_pkg::spmd_cmd_t    cmd;
  spmd_pkg::spmd_status_t status;

  spmd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .mode     (s_tuser[0]),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  spmd_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over one still waiting");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0] == spmd_pkg::MODE_LOAD) |=> !$rose(m_tvalid))
    else $error("edge load produced a result");

  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("unreachable target with non-zero distance");
`endif

endmodule

`default_nettype wire
